// File: rtl/segment_intersection_cross_product_top_defines.svh
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared concurrent assertion forms used by the segment intersection RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_CROSS_PRODUCT_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_CROSS_PRODUCT_TOP_DEFINES_SVH

// Same-cycle implication under synchronous reset
`define SICP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles
`define SICP_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// File: rtl/sicp_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared constants, codes and job control types.
// ----------------------------------------------------------------------------
`default_nettype none

package sicp_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int OUT_BITS       = 32;
   localparam int AREA_EPS_BITS  = 34;
   localparam int FRAC_EPS_BITS  = 16;
   localparam int CSR_DATA_BITS  = 34;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH    = 8;
   localparam int FRONT_STAGES   = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AREA_EPS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAC_EPS = 1'b1;

   // hit counts
   localparam logic [1:0] HIT_NONE = 2'd0;
   localparam logic [1:0] HIT_ONE  = 2'd1;
   localparam logic [1:0] HIT_TWO  = 2'd2;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_CROSS    = 2'd1,
      KIND_PARALLEL = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         t2_neg;
   } job_ctl_type;

endpackage

`default_nettype wire

// File: rtl/sicp_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Takes segment pairs, forms cross products and classifies each pair into a
// crossing, parallel or no-hit job with division operands.
// ----------------------------------------------------------------------------
`default_nettype none

module sicp_front import sicp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic signed [COORD_BITS-1:0]      a_start_x,
   input  wire logic signed [COORD_BITS-1:0]      a_start_y,
   input  wire logic signed [COORD_BITS-1:0]      a_end_x,
   input  wire logic signed [COORD_BITS-1:0]      a_end_y,
   input  wire logic signed [COORD_BITS-1:0]      b_start_x,
   input  wire logic signed [COORD_BITS-1:0]      b_start_y,
   input  wire logic signed [COORD_BITS-1:0]      b_end_x,
   input  wire logic signed [COORD_BITS-1:0]      b_end_y,
   input  wire logic [AREA_EPS_BITS-1:0]          area_eps,
   output logic                                   push_valid,
   output job_ctl_type                            push_ctl,
   output logic [2*COORD_BITS+4:0]                push_num1,
   output logic [2*COORD_BITS+4:0]                push_num2,
   output logic [2*COORD_BITS+4:0]                push_den,
   output logic signed [COORD_BITS-1:0]           push_ax,
   output logic signed [COORD_BITS-1:0]           push_ay,
   output logic signed [COORD_BITS:0]             push_v1x,
   output logic signed [COORD_BITS:0]             push_v1y
);

   localparam int VW   = COORD_BITS + 1;
   localparam int PRW  = 2 * COORD_BITS + 2;
   localparam int PW   = 2 * COORD_BITS + 6;
   localparam int DW   = 2 * COORD_BITS + 5;
   localparam int CMPW = (PW > AREA_EPS_BITS) ? PW : AREA_EPS_BITS;

   // stage 1: differences
   logic                  s1_vld_ff;
   logic signed [VW-1:0]  s1_v1x_ff, s1_v1y_ff, s1_v2x_ff, s1_v2y_ff;
   logic signed [VW-1:0]  s1_dx_ff, s1_dy_ff, s1_ex_ff, s1_ey_ff;
   logic signed [COORD_BITS-1:0] s1_ax_ff, s1_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_v1x_ff <= VW'(a_end_x) - VW'(a_start_x);
      s1_v1y_ff <= VW'(a_end_y) - VW'(a_start_y);
      s1_v2x_ff <= VW'(b_end_x) - VW'(b_start_x);
      s1_v2y_ff <= VW'(b_end_y) - VW'(b_start_y);
      s1_dx_ff  <= VW'(b_start_x) - VW'(a_start_x);
      s1_dy_ff  <= VW'(b_start_y) - VW'(a_start_y);
      s1_ex_ff  <= VW'(b_end_x) - VW'(a_start_x);
      s1_ey_ff  <= VW'(b_end_y) - VW'(a_start_y);
      s1_ax_ff  <= a_start_x;
      s1_ay_ff  <= a_start_y;
   end

   // stage 2: products
   logic                  s2_vld_ff;
   logic signed [PRW-1:0] s2_det_a_ff, s2_det_b_ff, s2_col_a_ff, s2_col_b_ff;
   logic signed [PRW-1:0] s2_cn_a_ff, s2_cn_b_ff, s2_len_a_ff, s2_len_b_ff;
   logic signed [PRW-1:0] s2_pn_a_ff, s2_pn_b_ff, s2_qn_a_ff, s2_qn_b_ff;
   logic signed [COORD_BITS-1:0] s2_ax_ff, s2_ay_ff;
   logic signed [VW-1:0]  s2_v1x_ff, s2_v1y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_det_a_ff <= s1_v1y_ff * s1_v2x_ff;
      s2_det_b_ff <= s1_v1x_ff * s1_v2y_ff;
      s2_col_a_ff <= s1_dx_ff * s1_v1y_ff;
      s2_col_b_ff <= s1_dy_ff * s1_v1x_ff;
      s2_cn_a_ff  <= s1_dy_ff * s1_v2x_ff;
      s2_cn_b_ff  <= s1_dx_ff * s1_v2y_ff;
      s2_len_a_ff <= s1_v1x_ff * s1_v1x_ff;
      s2_len_b_ff <= s1_v1y_ff * s1_v1y_ff;
      s2_pn_a_ff  <= s1_v1x_ff * s1_dx_ff;
      s2_pn_b_ff  <= s1_v1y_ff * s1_dy_ff;
      s2_qn_a_ff  <= s1_v1x_ff * s1_ex_ff;
      s2_qn_b_ff  <= s1_v1y_ff * s1_ey_ff;
      s2_ax_ff    <= s1_ax_ff;
      s2_ay_ff    <= s1_ay_ff;
      s2_v1x_ff   <= s1_v1x_ff;
      s2_v1y_ff   <= s1_v1y_ff;
   end

   // stage 3: determinant, cross products and projections
   logic                  s3_vld_ff;
   logic signed [PW-1:0]  s3_det_ff, s3_col_ff, s3_cn_ff, s3_len_ff, s3_pn_ff, s3_qn_ff;
   logic signed [COORD_BITS-1:0] s3_ax_ff, s3_ay_ff;
   logic signed [VW-1:0]  s3_v1x_ff, s3_v1y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_det_ff <= PW'(s2_det_a_ff) - PW'(s2_det_b_ff);
      s3_col_ff <= PW'(s2_col_a_ff) - PW'(s2_col_b_ff);
      s3_cn_ff  <= PW'(s2_cn_a_ff) - PW'(s2_cn_b_ff);
      s3_len_ff <= PW'(s2_len_a_ff) + PW'(s2_len_b_ff);
      s3_pn_ff  <= PW'(s2_pn_a_ff) + PW'(s2_pn_b_ff);
      s3_qn_ff  <= PW'(s2_qn_a_ff) + PW'(s2_qn_b_ff);
      s3_ax_ff  <= s2_ax_ff;
      s3_ay_ff  <= s2_ay_ff;
      s3_v1x_ff <= s2_v1x_ff;
      s3_v1y_ff <= s2_v1y_ff;
   end

   // classify
   logic signed [PW-1:0] det_mag, col_mag, cross_n1, cross_n2;
   logic signed [PW-1:0] lo_raw, hi_raw, lo_pos, hi_cap, lo_cl, hi_cl, hi_mag, twice_len;
   logic                 is_parallel, not_collinear, cross_in;

   always_comb begin
      det_mag       = s3_det_ff[PW-1] ? -s3_det_ff : s3_det_ff;
      col_mag       = s3_col_ff[PW-1] ? -s3_col_ff : s3_col_ff;
      is_parallel   = (s3_det_ff == '0) || (CMPW'($unsigned(det_mag)) < CMPW'(area_eps));
      not_collinear = CMPW'($unsigned(col_mag)) > CMPW'(area_eps);

      // order and clamp the projections of B onto A
      lo_raw    = (s3_pn_ff > s3_qn_ff) ? s3_qn_ff : s3_pn_ff;
      hi_raw    = (s3_pn_ff > s3_qn_ff) ? s3_pn_ff : s3_qn_ff;
      twice_len = s3_len_ff <<< 1;
      lo_pos    = lo_raw[PW-1] ? '0 : lo_raw;
      hi_cap    = (hi_raw > s3_len_ff) ? s3_len_ff : hi_raw;
      lo_cl     = (lo_pos > twice_len) ? twice_len : lo_pos;
      hi_cl     = (hi_cap < -s3_len_ff) ? -s3_len_ff : hi_cap;
      hi_mag    = hi_cl[PW-1] ? -hi_cl : hi_cl;

      // crossing parameters with a positive denominator
      cross_n1 = s3_det_ff[PW-1] ? -s3_cn_ff : s3_cn_ff;
      cross_n2 = s3_det_ff[PW-1] ? s3_col_ff : -s3_col_ff;
      cross_in = !cross_n1[PW-1] && (cross_n1 <= det_mag) &&
                 !cross_n2[PW-1] && (cross_n2 <= det_mag);

      push_ctl.t2_neg = 1'b0;
      push_num1       = cross_n1[DW-1:0];
      push_num2       = '0;
      push_den        = det_mag[DW-1:0];
      if (is_parallel) begin
         push_num1       = lo_cl[DW-1:0];
         push_num2       = hi_mag[DW-1:0];
         push_den        = s3_len_ff[DW-1:0];
         push_ctl.t2_neg = hi_cl[PW-1];
         if (not_collinear || (s3_len_ff == '0)) begin
            push_ctl.kind = KIND_NONE;
         end else begin
            push_ctl.kind = KIND_PARALLEL;
         end
      end else if (cross_in) begin
         push_ctl.kind = KIND_CROSS;
      end else begin
         push_ctl.kind = KIND_NONE;
      end
   end

   assign push_valid = s3_vld_ff;
   assign push_ax    = s3_ax_ff;
   assign push_ay    = s3_ay_ff;
   assign push_v1x   = s3_v1x_ff;
   assign push_v1y   = s3_v1y_ff;

endmodule

`default_nettype wire

// File: rtl/sicp_queue.sv
// ----------------------------------------------------------------------------
// Segment intersection job queue
// Small FIFO between front end and back end, drained one beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "segment_intersection_cross_product_top_defines.svh"

module sicp_queue import sicp_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   input  wire logic [WIDTH-1:0]           push_data,
   output logic                            pop_valid,
   output logic [WIDTH-1:0]                pop_data,
   output logic [$clog2(DEPTH+1)-1:0]      level
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             pop_valid_ff;
   logic [WIDTH-1:0] pop_data_ff;
   logic             take;

   assign take = (count_ff != '0);

   // advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (take) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         count_ff     <= count_ff + CW'(push_valid) - CW'(take);
         pop_valid_ff <= take;
      end
   end

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (take) begin
         pop_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign pop_valid = pop_valid_ff;
   assign pop_data  = pop_data_ff;
   assign level     = count_ff;

   `SICP_ASSERT_IMPL(a_queue_no_overflow, clock, reset, push_valid, count_ff != CW'(DEPTH), "job queue overflow")

endmodule

`default_nettype wire

// File: rtl/sicp_back.sv
// ----------------------------------------------------------------------------
// Segment intersection back end
// Two-lane pipelined restoring divider for the segment parameters, overlap
// decision, point multiply and Q-format saturation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "segment_intersection_cross_product_top_defines.svh"

module sicp_back import sicp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   input  wire job_ctl_type                   job_ctl,
   input  wire logic [2*COORD_BITS+4:0]       job_num1,
   input  wire logic [2*COORD_BITS+4:0]       job_num2,
   input  wire logic [2*COORD_BITS+4:0]       job_den,
   input  wire logic signed [COORD_BITS-1:0]  job_ax,
   input  wire logic signed [COORD_BITS-1:0]  job_ay,
   input  wire logic signed [COORD_BITS:0]    job_v1x,
   input  wire logic signed [COORD_BITS:0]    job_v1y,
   input  wire logic [FRAC_EPS_BITS-1:0]      frac_eps,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_hit_count,
   output logic signed [OUT_BITS-1:0]         rsp_first_x,
   output logic signed [OUT_BITS-1:0]         rsp_first_y,
   output logic signed [OUT_BITS-1:0]         rsp_second_x,
   output logic signed [OUT_BITS-1:0]         rsp_second_y
);

   localparam int DW   = 2 * COORD_BITS + 5;
   localparam int QW   = FRAC_BITS + 3;
   localparam int TW   = FRAC_BITS + 2;
   localparam int NS   = FRAC_BITS + 2;
   localparam int SW   = FRAC_BITS + 4;
   localparam int VW   = COORD_BITS + 1;
   localparam int MW   = TW + COORD_BITS + 2;
   localparam int SUMW = MW + 1;
   localparam int XW   = (SUMW > OUT_BITS + 1) ? SUMW : OUT_BITS + 1;
   localparam logic signed [XW-1:0] SAT_HI = XW'(64'sh7fffffff);
   localparam logic signed [XW-1:0] SAT_LO = XW'(-64'sh80000000);

   function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [XW-1:0] v);
      logic [OUT_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[OUT_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[OUT_BITS-1:0];
      end else begin
         r = v[OUT_BITS-1:0];
      end
      return r;
   endfunction

   // divider stage registers, lane 0 for t1, lane 1 for |t2|
   logic                         vld_ff [0:NS-1];
   logic [DW-1:0]                rem_ff [0:NS-1][0:1];
   logic [QW-1:0]                quo_ff [0:NS-1][0:1];
   logic [DW-1:0]                den_ff [0:NS-1];
   job_ctl_type                  ctl_ff [0:NS-1];
   logic signed [COORD_BITS-1:0] ax_ff  [0:NS-1];
   logic signed [COORD_BITS-1:0] ay_ff  [0:NS-1];
   logic signed [VW-1:0]         v1x_ff [0:NS-1];
   logic signed [VW-1:0]         v1y_ff [0:NS-1];

   logic [DW-1:0] job_num [0:1];
   logic [DW:0]   twice_den;
   logic [DW-1:0] rem0 [0:1];
   logic [QW-1:0] quo0 [0:1];
   logic [DW:0]   r2   [1:NS-1][0:1];
   logic          qbit [1:NS-1][0:1];

   assign job_num[0] = job_num1;
   assign job_num[1] = job_num2;

   // integer part of the quotient, at most two
   always_comb begin
      twice_den = {job_den, 1'b0};
      for (int l = 0; l < 2; l++) begin
         if ({1'b0, job_num[l]} >= twice_den) begin
            rem0[l] = DW'({1'b0, job_num[l]} - twice_den);
            quo0[l] = QW'(2);
         end else if (job_num[l] >= job_den) begin
            rem0[l] = job_num[l] - job_den;
            quo0[l] = QW'(1);
         end else begin
            rem0[l] = job_num[l];
            quo0[l] = '0;
         end
      end
   end

   // one restoring step per stage
   always_comb begin
      for (int k = 1; k < NS; k++) begin
         for (int l = 0; l < 2; l++) begin
            r2[k][l]   = {rem_ff[k-1][l], 1'b0};
            qbit[k][l] = r2[k][l] >= {1'b0, den_ff[k-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= job_valid;
         for (int k = 1; k < NS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         rem_ff[0][l] <= rem0[l];
         quo_ff[0][l] <= quo0[l];
      end
      den_ff[0] <= job_den;
      ctl_ff[0] <= job_ctl;
      ax_ff[0]  <= job_ax;
      ay_ff[0]  <= job_ay;
      v1x_ff[0] <= job_v1x;
      v1y_ff[0] <= job_v1y;
      for (int k = 1; k < NS; k++) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[k][l] <= qbit[k][l] ? DW'(r2[k][l] - {1'b0, den_ff[k-1]})
                                       : r2[k][l][DW-1:0];
            quo_ff[k][l] <= {quo_ff[k-1][l][QW-2:0], qbit[k][l]};
         end
         den_ff[k] <= den_ff[k-1];
         ctl_ff[k] <= ctl_ff[k-1];
         ax_ff[k]  <= ax_ff[k-1];
         ay_ff[k]  <= ay_ff[k-1];
         v1x_ff[k] <= v1x_ff[k-1];
         v1y_ff[k] <= v1y_ff[k-1];
      end
   end

   // round half up and decide the hit count
   logic [QW-1:0]          q_round [0:1];
   logic [TW-1:0]          t_val   [0:1];
   logic [FRAC_BITS+15:0]  eps_wide;
   logic signed [SW-1:0]   t1_s, t2_mag, t2_s, eps_s;
   logic [1:0]             hit_in;

   assign eps_wide = {frac_eps, {FRAC_BITS{1'b0}}};

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         q_round[l] = quo_ff[NS-1][l] + QW'(1);
         t_val[l]   = q_round[l][QW-1:1];
      end
      t1_s   = $signed(SW'(t_val[0]));
      t2_mag = $signed(SW'(t_val[1]));
      t2_s   = ctl_ff[NS-1].t2_neg ? -t2_mag : t2_mag;
      eps_s  = $signed(SW'(eps_wide[FRAC_EPS_BITS +: FRAC_BITS]));
      case (ctl_ff[NS-1].kind)
         KIND_CROSS: begin
            hit_in = HIT_ONE;
         end
         KIND_PARALLEL: begin
            if (t1_s > t2_s + eps_s) begin
               hit_in = HIT_NONE;
            end else if (t1_s + eps_s > t2_s) begin
               hit_in = HIT_ONE;
            end else begin
               hit_in = HIT_TWO;
            end
         end
         default: begin
            hit_in = HIT_NONE;
         end
      endcase
   end

   logic                         dec_vld_ff;
   logic [1:0]                   dec_hit_ff;
   logic [TW-1:0]                dec_ta_ff, dec_tb_ff;
   logic signed [COORD_BITS-1:0] dec_ax_ff, dec_ay_ff;
   logic signed [VW-1:0]         dec_v1x_ff, dec_v1y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_vld_ff <= 1'b0;
      end else begin
         dec_vld_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      dec_hit_ff <= hit_in;
      dec_ta_ff  <= t_val[0];
      dec_tb_ff  <= t_val[1];
      dec_ax_ff  <= ax_ff[NS-1];
      dec_ay_ff  <= ay_ff[NS-1];
      dec_v1x_ff <= v1x_ff[NS-1];
      dec_v1y_ff <= v1y_ff[NS-1];
   end

   // scale the direction by the parameters
   logic                         mul_vld_ff;
   logic [1:0]                   mul_hit_ff;
   logic signed [MW-1:0]         mul_xa_ff, mul_ya_ff, mul_xb_ff, mul_yb_ff;
   logic signed [COORD_BITS-1:0] mul_ax_ff, mul_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= dec_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_hit_ff <= dec_hit_ff;
      mul_xa_ff  <= $signed({1'b0, dec_ta_ff}) * dec_v1x_ff;
      mul_ya_ff  <= $signed({1'b0, dec_ta_ff}) * dec_v1y_ff;
      mul_xb_ff  <= $signed({1'b0, dec_tb_ff}) * dec_v1x_ff;
      mul_yb_ff  <= $signed({1'b0, dec_tb_ff}) * dec_v1y_ff;
      mul_ax_ff  <= dec_ax_ff;
      mul_ay_ff  <= dec_ay_ff;
   end

   // add the start point, saturate and drop unused points
   logic signed [SUMW-1:0] base_x, base_y;
   logic [OUT_BITS-1:0]    pt_xa, pt_ya, pt_xb, pt_yb;

   always_comb begin
      base_x = SUMW'(mul_ax_ff) <<< FRAC_BITS;
      base_y = SUMW'(mul_ay_ff) <<< FRAC_BITS;
      pt_xa  = sat_out(XW'(base_x + SUMW'(mul_xa_ff)));
      pt_ya  = sat_out(XW'(base_y + SUMW'(mul_ya_ff)));
      pt_xb  = sat_out(XW'(base_x + SUMW'(mul_xb_ff)));
      pt_yb  = sat_out(XW'(base_y + SUMW'(mul_yb_ff)));
   end

   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_hit_count_ff;
   logic signed [OUT_BITS-1:0] rsp_first_x_ff, rsp_first_y_ff;
   logic signed [OUT_BITS-1:0] rsp_second_x_ff, rsp_second_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_count_ff <= mul_hit_ff;
      rsp_first_x_ff   <= (mul_hit_ff != HIT_NONE) ? pt_xa : '0;
      rsp_first_y_ff   <= (mul_hit_ff != HIT_NONE) ? pt_ya : '0;
      rsp_second_x_ff  <= (mul_hit_ff == HIT_TWO) ? pt_xb : '0;
      rsp_second_y_ff  <= (mul_hit_ff == HIT_TWO) ? pt_yb : '0;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_count = rsp_hit_count_ff;
   assign rsp_first_x   = rsp_first_x_ff;
   assign rsp_first_y   = rsp_first_y_ff;
   assign rsp_second_x  = rsp_second_x_ff;
   assign rsp_second_y  = rsp_second_y_ff;

   `SICP_ASSERT_IMPL(a_hit_range, clock, reset, rsp_valid_ff, rsp_hit_count_ff == HIT_NONE || rsp_hit_count_ff == HIT_ONE || rsp_hit_count_ff == HIT_TWO, "hit count out of range")
   `SICP_ASSERT_IMPL(a_second_clear, clock, reset, rsp_valid_ff && rsp_hit_count_ff != HIT_TWO, rsp_second_x_ff == '0 && rsp_second_y_ff == '0, "second point not cleared")
   `SICP_ASSERT_DELAY(a_back_latency, clock, reset, vld_ff[0], (NS+2), rsp_valid_ff, "divider job lost in back end")

endmodule

`default_nettype wire

// File: rtl/segment_intersection_cross_product_top.sv
// A pair passes the front end, queue, divider, decision, multiply and output registers.
// Throughput: one pair per cycle while busy is low; one divider quotient bit per stage.
// busy rises only if the job queue nears full; with the back end draining a beat
// every cycle it stays low in steady streaming.
// Reset: synchronous, clears all valid flags, queue pointers and both tolerance registers.
// ----------------------------------------------------------------------------
// Segment intersection top level
// Front end, job queue, back end and the tolerance registers.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_cross_product_top import sicp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_BITS-1:0]  req_a_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_a_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_a_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_a_end_y,
   input  wire logic signed [COORD_BITS-1:0]  req_b_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_b_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_b_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_b_end_y,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_hit_count,
   output logic signed [OUT_BITS-1:0]         rsp_first_x,
   output logic signed [OUT_BITS-1:0]         rsp_first_y,
   output logic signed [OUT_BITS-1:0]         rsp_second_x,
   output logic signed [OUT_BITS-1:0]         rsp_second_y,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int DW   = 2 * COORD_BITS + 5;
   localparam int CTLW = $bits(job_ctl_type);
   localparam int QDW  = CTLW + 3 * DW + 4 * COORD_BITS + 2;
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);

   // tolerance registers
   logic [AREA_EPS_BITS-1:0] area_eps_ff;
   logic [FRAC_EPS_BITS-1:0] frac_eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_eps_ff <= '0;
         frac_eps_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AREA_EPS: area_eps_ff <= csr_wdata[AREA_EPS_BITS-1:0];
            CSR_FRAC_EPS: frac_eps_ff <= csr_wdata[FRAC_EPS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   logic accept;
   logic [CW-1:0] queue_level;

   // hold off new pairs while the queue cannot absorb the front end contents
   assign busy   = queue_level > CW'(QUEUE_DEPTH - FRONT_STAGES - 1);
   assign accept = start && !busy;

   logic                          push_valid;
   job_ctl_type                   push_ctl;
   logic [DW-1:0]                 push_num1, push_num2, push_den;
   logic signed [COORD_BITS-1:0]  push_ax, push_ay;
   logic signed [COORD_BITS:0]    push_v1x, push_v1y;

   sicp_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .a_start_x  (req_a_start_x),
      .a_start_y  (req_a_start_y),
      .a_end_x    (req_a_end_x),
      .a_end_y    (req_a_end_y),
      .b_start_x  (req_b_start_x),
      .b_start_y  (req_b_start_y),
      .b_end_x    (req_b_end_x),
      .b_end_y    (req_b_end_y),
      .area_eps   (area_eps_ff),
      .push_valid (push_valid),
      .push_ctl   (push_ctl),
      .push_num1  (push_num1),
      .push_num2  (push_num2),
      .push_den   (push_den),
      .push_ax    (push_ax),
      .push_ay    (push_ay),
      .push_v1x   (push_v1x),
      .push_v1y   (push_v1y)
   );

   logic [QDW-1:0] push_data, pop_data;
   logic           pop_valid;

   assign push_data = {push_ctl, push_num1, push_num2, push_den,
                       push_ax, push_ay, push_v1x, push_v1y};

   sicp_queue #(
      .WIDTH (QDW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .level      (queue_level)
   );

   job_ctl_type                   pop_ctl;
   logic [DW-1:0]                 pop_num1, pop_num2, pop_den;
   logic signed [COORD_BITS-1:0]  pop_ax, pop_ay;
   logic signed [COORD_BITS:0]    pop_v1x, pop_v1y;

   assign {pop_ctl, pop_num1, pop_num2, pop_den,
           pop_ax, pop_ay, pop_v1x, pop_v1y} = pop_data;

   sicp_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (pop_valid),
      .job_ctl       (pop_ctl),
      .job_num1      (pop_num1),
      .job_num2      (pop_num2),
      .job_den       (pop_den),
      .job_ax        (pop_ax),
      .job_ay        (pop_ay),
      .job_v1x       (pop_v1x),
      .job_v1y       (pop_v1y),
      .frac_eps      (frac_eps_ff),
      .rsp_valid     (rsp_valid),
      .rsp_hit_count (rsp_hit_count),
      .rsp_first_x   (rsp_first_x),
      .rsp_first_y   (rsp_first_y),
      .rsp_second_x  (rsp_second_x),
      .rsp_second_y  (rsp_second_y)
   );

endmodule

`default_nettype wire

// File: bench/tb_segment_intersection_cross_product_top.sv
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Streams segment pairs into the block and checks every result beat against
// a local fixed-point predictor across several tolerance settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection_cross_product_top;
   import sicp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int SETTLE_CYCLES = FB + 20;

   typedef struct {
      logic [1:0]         hits;
      logic signed [31:0] fx, fy, sx, sy;
   } hit_result_type;

   typedef struct {
      logic signed [CB-1:0] ax, ay, aex, aey, bx, by, bex, bey;
   } seg_pair_type;

   // --------------------------------------------------------------------------
   // Scoreboard: predicts the intersection and checks result beats in order
   // --------------------------------------------------------------------------
   class intersect_scoreboard;
      hit_result_type pending[$];
      logic [AREA_EPS_BITS-1:0] area_tol;
      logic [FRAC_EPS_BITS-1:0] frac_tol;
      int errors;

      function void clear_tol();
         area_tol = '0;
         frac_tol = '0;
      endfunction

      // round(n * 2^FB / d), half up
      function automatic longint ratio_q(longint n, longint d);
         longint q, r;
         q = n / d;
         r = n % d;
         for (int i = 0; i < FB + 1; i++) begin
            q = q <<< 1;
            r = r <<< 1;
            if (r >= d) begin
               q++;
               r -= d;
            end
         end
         return (q + 1) >>> 1;
      endfunction

      function automatic logic signed [31:0] point_on(longint s, longint t, longint dv);
         longint p;
         p = s * (longint'(1) <<< FB) + t * dv;
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         if (p < -64'sd2147483648) p = -64'sd2147483648;
         return p[31:0];
      endfunction

      function automatic longint magn(longint v);
         return v < 0 ? -v : v;
      endfunction

      function void note_pair(seg_pair_type s);
         hit_result_type e;
         longint ax, ay, v1x, v1y, v2x, v2y, dx, dy, det, eps, col, len2;
         longint n1, n2, tmp, t1, t2, d, atol;
         ax = s.ax; ay = s.ay;
         v1x = longint'(s.aex) - ax; v1y = longint'(s.aey) - ay;
         v2x = longint'(s.bex) - s.bx; v2y = longint'(s.bey) - s.by;
         dx = longint'(s.bx) - ax; dy = longint'(s.by) - ay;
         det = v1y * v2x - v1x * v2y;
         atol = longint'({30'd0, area_tol});
         eps = (FB >= 16) ? (longint'(frac_tol) <<< (FB - 16))
                          : (longint'(frac_tol) >>> (16 - FB));
         e = '{HIT_NONE, 0, 0, 0, 0};
         if (det == 0 || magn(det) < atol) begin
            col = dx * v1y - dy * v1x;
            len2 = v1x * v1x + v1y * v1y;
            if (magn(col) <= atol && len2 != 0) begin
               n1 = v1x * dx + v1y * dy;
               n2 = v1x * (longint'(s.bex) - ax) + v1y * (longint'(s.bey) - ay);
               if (n1 > n2) begin
                  tmp = n1; n1 = n2; n2 = tmp;
               end
               if (n1 < 0) n1 = 0;
               if (n2 > len2) n2 = len2;
               if (n1 > 2 * len2) n1 = 2 * len2;
               if (n2 < -len2) n2 = -len2;
               t1 = ratio_q(n1, len2);
               t2 = n2 < 0 ? -ratio_q(-n2, len2) : ratio_q(n2, len2);
               if (!(t1 > t2 + eps)) begin
                  e.fx = point_on(ax, t1, v1x);
                  e.fy = point_on(ay, t1, v1y);
                  if (t1 + eps > t2) e.hits = HIT_ONE;
                  else begin
                     e.sx = point_on(ax, t2, v1x);
                     e.sy = point_on(ay, t2, v1y);
                     e.hits = HIT_TWO;
                  end
               end
            end
         end else begin
            n1 = dy * v2x - dx * v2y;
            n2 = v1x * dy - v1y * dx;
            d = det;
            if (d < 0) begin
               d = -d; n1 = -n1; n2 = -n2;
            end
            if (!(n1 < 0 || n1 > d || n2 < 0 || n2 > d)) begin
               t1 = ratio_q(n1, d);
               e.hits = HIT_ONE;
               e.fx = point_on(ax, t1, v1x);
               e.fy = point_on(ay, t1, v1y);
            end
         end
         pending.insert(pending.size(), e);
      endfunction

      function void check_beat(hit_result_type got);
         hit_result_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("result beat with nothing pending: hits=%0d", got.hits);
            return;
         end
         e = pending.pop_front();
         if (got.hits !== e.hits || got.fx !== e.fx || got.fy !== e.fy ||
             got.sx !== e.sx || got.sy !== e.sy) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp %0d (%0d,%0d) (%0d,%0d) got %0d (%0d,%0d) (%0d,%0d)",
                  e.hits, e.fx, e.fy, e.sx, e.sy, got.hits, got.fx, got.fy, got.sx, got.sy);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CB-1:0] req_ax = '0, req_ay = '0, req_aex = '0, req_aey = '0;
   logic signed [CB-1:0] req_bx = '0, req_by = '0, req_bex = '0, req_bey = '0;
   logic rsp_valid;
   logic [1:0] rsp_hit_count;
   logic signed [OUT_BITS-1:0] rsp_first_x, rsp_first_y, rsp_second_x, rsp_second_y;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   intersect_scoreboard board;

   segment_intersection_cross_product_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(req_ax), .req_a_start_y(req_ay),
      .req_a_end_x(req_aex), .req_a_end_y(req_aey),
      .req_b_start_x(req_bx), .req_b_start_y(req_by),
      .req_b_end_x(req_bex), .req_b_end_y(req_bey),
      .rsp_valid(rsp_valid), .rsp_hit_count(rsp_hit_count),
      .rsp_first_x(rsp_first_x), .rsp_first_y(rsp_first_y),
      .rsp_second_x(rsp_second_x), .rsp_second_y(rsp_second_y),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check every strobed result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && board != null)
         board.check_beat('{rsp_hit_count, rsp_first_x, rsp_first_y,
                            rsp_second_x, rsp_second_y});
   end

   // Note accepted pair beats from the request ports
   always @(posedge clock) begin
      if (!reset && start && !busy && board != null)
         board.note_pair('{req_ax, req_ay, req_aex, req_aey,
                           req_bx, req_by, req_bex, req_bey});
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_AREA_EPS) board.area_tol = val[AREA_EPS_BITS-1:0];
      else board.frac_tol = val[FRAC_EPS_BITS-1:0];
   endtask

   // Hold the pair until accepted; keep start high when another beat follows
   task automatic send_pair(input seg_pair_type s, input bit keep);
      start <= 1'b1;
      {req_ax, req_ay, req_aex, req_aey} <= {s.ax, s.ay, s.aex, s.aey};
      {req_bx, req_by, req_bex, req_bey} <= {s.bx, s.by, s.bex, s.bey};
      @(posedge clock);
      while (busy) @(posedge clock);
      if (!keep) start <= 1'b0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Build a pair from integer coordinates
   function automatic seg_pair_type make_pair(int ax, int ay, int aex, int aey,
                                              int bx, int by, int bex, int bey);
      seg_pair_type s;
      s.ax = CB'(ax); s.ay = CB'(ay); s.aex = CB'(aex); s.aey = CB'(aey);
      s.bx = CB'(bx); s.by = CB'(by); s.bex = CB'(bex); s.bey = CB'(bey);
      return s;
   endfunction

   function automatic logic signed [CB-1:0] rnd_coord();
      case ($urandom_range(0, 3))
         0: return CB'($urandom_range(0, 15) - 8);
         1: return $urandom_range(0, 1) ? CB'(16'sh7FFF - $urandom_range(0, 3))
                                        : CB'(16'sh8000 + $urandom_range(0, 3));
         2: return CB'($urandom_range(0, 400) - 200);
         default: return CB'($urandom());
      endcase
   endfunction

   // Mostly crossing, collinear or touching shapes with random content
   function automatic seg_pair_type rnd_pair();
      seg_pair_type s;
      int k, m;
      logic signed [CB-1:0] ox, oy, ux, uy;
      s = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
            rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
      k = $urandom_range(0, 9);
      ox = CB'($urandom_range(0, 200) - 100);
      oy = CB'($urandom_range(0, 200) - 100);
      ux = CB'($urandom_range(0, 40) - 20);
      uy = CB'($urandom_range(0, 40) - 20);
      if (k < 4) begin
         // collinear pair along one direction
         m = 10;
         s.ax = ox; s.ay = oy;
         s.aex = CB'(ox + ux * m); s.aey = CB'(oy + uy * m);
         s.bx = CB'(ox + ux * ($urandom_range(0, 30) - 10));
         s.by = CB'(oy + uy * ($urandom_range(0, 30) - 10));
         s.bex = CB'(ox + ux * ($urandom_range(0, 30) - 10));
         s.bey = CB'(oy + uy * ($urandom_range(0, 30) - 10));
         if (k == 3) s.bx = CB'(s.bx + $urandom_range(0, 2) - 1);
      end else if (k < 8) begin
         // small crossing-prone segments around a center
         s.ax = CB'(ox - ux); s.ay = CB'(oy - uy);
         s.aex = CB'(ox + ux); s.aey = CB'(oy + uy);
         s.bx = CB'(ox + $urandom_range(0, 40) - 20);
         s.by = CB'(oy + $urandom_range(0, 40) - 20);
         s.bex = CB'(2 * ox - s.bx + $urandom_range(0, 6) - 3);
         s.bey = CB'(2 * oy - s.by + $urandom_range(0, 6) - 3);
      end
      return s;
   endfunction

   task automatic run_random(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && count > 0) begin
            send_pair(rnd_pair(), burst > 1 && count > 1);
            burst--;
            count--;
         end
         start <= 1'b0;
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start <= 1'b0;
   endtask

   initial begin
      seg_pair_type dir[$];
      int mx, mn;
      mx = 32767;
      mn = -32768;
      board = new();
      board.clear_tol();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: crossing, miss, parallel, collinear overlap, touch, degenerate
      dir.insert(dir.size(), make_pair(0, 0, 10, 10, 0, 10, 10, 0));
      dir.insert(dir.size(), make_pair(0, 0, 10, 10, 20, 0, 30, -10));
      dir.insert(dir.size(), make_pair(0, 0, 10, 0, 0, 5, 10, 5));
      dir.insert(dir.size(), make_pair(0, 0, 10, 0, 3, 0, 7, 0));
      dir.insert(dir.size(), make_pair(0, 0, 10, 0, 12, 0, -4, 0));
      dir.insert(dir.size(), make_pair(0, 0, 10, 0, 10, 0, 20, 0));
      dir.insert(dir.size(), make_pair(0, 0, 10, 0, 11, 0, 20, 0));
      dir.insert(dir.size(), make_pair(5, 5, 5, 5, 5, 5, 9, 9));
      dir.insert(dir.size(), make_pair(0, 0, 10, 0, -5, 0, -1, 0));
      dir.insert(dir.size(), make_pair(0, 0, 10, 10, 10, 10, 20, 0));
      dir.insert(dir.size(), make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
      dir.insert(dir.size(), make_pair(mx, mn, mn, mx, mx, mx, mn, mn));
      dir.insert(dir.size(), make_pair(mn, mn, mx, mn, mn, mn, mx, mn));
      dir.insert(dir.size(), make_pair(mx, mx, mn, mn, mn, mn, mx, mx));
      dir.insert(dir.size(), make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
      dir.insert(dir.size(), make_pair(0, 0, 3, 1, 0, 1, 3, 0));
      foreach (dir[i]) send_pair(dir[i], i != dir.size() - 1);
      start <= 1'b0;
      drain();

      // Loose tolerances: near-parallel and near-touching pairs
      write_reg(CSR_AREA_EPS, CSR_DATA_BITS'(50));
      write_reg(CSR_FRAC_EPS, CSR_DATA_BITS'(2000));
      send_pair(make_pair(0, 0, 100, 0, 0, 0, 100, 1), 1);
      send_pair(make_pair(0, 0, 10, 0, 10, 0, 20, 0), 1);
      send_pair(make_pair(0, 0, 100, 0, 101, 0, 200, 0), 0);
      start <= 1'b0;
      run_random(300);
      drain();

      // Extremes of both registers
      write_reg(CSR_AREA_EPS, {CSR_DATA_BITS{1'b1}});
      write_reg(CSR_FRAC_EPS, CSR_DATA_BITS'(16'hFFFF));
      run_random(250);
      drain();

      write_reg(CSR_AREA_EPS, 34'h2_AAAA_5555);
      write_reg(CSR_FRAC_EPS, CSR_DATA_BITS'(16'h5AA5));
      run_random(200);
      drain();

      write_reg(CSR_AREA_EPS, '0);
      write_reg(CSR_FRAC_EPS, '0);
      run_random(500);
      drain();

      if (board.errors == 0) $display("PASS segment_intersection_cross_product_top");
      else $display("FAIL segment_intersection_cross_product_top");
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("FAIL segment_intersection_cross_product_top");
      $finish;
   end

endmodule

`default_nettype wire
